// ===== design/qte_pkg.sv =====
// Shared widths, constants, the arctangent table and the term record
// of the quaternion to Euler angle converter. Depends on nothing.
`timescale 1ns / 1ps
package qte_pkg;

	localparam int QW = 16;          // quaternion component width
	localparam int PW = 32;          // product of two components
	localparam int TW = 36;          // sine and cosine terms, Q28
	localparam int CW = 44;          // normalized rotation vector
	localparam int ZW = 26;          // angle accumulator, 1/65536 degree
	localparam int RW = 17;          // rounded angle, 1/128 degree
	localparam int STEPS = 22;       // rotation steps
	localparam int NORM_MSB = 40;    // target top bit after normalization
	localparam int SQ_STEPS = 29;    // root bits of the cosine of pitch
	localparam int RADW = 2 * SQ_STEPS;
	localparam int REMW = SQ_STEPS + 4;
	localparam int QUEUE_DEPTH = 4;
	localparam int ROLLW = 16;
	localparam int PITCHW = 15;

	localparam logic signed [TW-1:0] ONE_Q28 = TW'(64'sd268435456);
	localparam logic signed [ZW-1:0] HALF_TURN = ZW'(32'sd11796480);
	localparam logic signed [RW-1:0] LIM_HALF = RW'(23040);
	localparam logic signed [RW-1:0] LIM_QUARTER = RW'(11520);

	// atan(2^-i) in degrees scaled by 65536, rounded to nearest.
	localparam logic [21:0] ATAN_TAB [STEPS] = '{
		22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
		22'd58670, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833, 22'd917,
		22'd458, 22'd229, 22'd115, 22'd57, 22'd29, 22'd14, 22'd7, 22'd4, 22'd2
	};

	typedef struct packed {
		logic signed [TW-1:0] sinr;
		logic signed [TW-1:0] cosr;
		logic signed [TW-1:0] sinp;
		logic signed [TW-1:0] siny;
		logic signed [TW-1:0] cosy;
	} terms_t;

endpackage

// ===== design/qte_front.sv =====
// Front end: accepts quaternion transactions and forms the five sine and
// cosine terms in three stages. Depends on qte_pkg.
`timescale 1ns / 1ps
module qte_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [63:0]          s_tdata,   // quat_x, quat_y, quat_z, quat_w
	output logic                 q_valid,
	input  logic                 q_ready,
	output qte_pkg::terms_t      q_data
);

	logic en;
	logic v_s1, v_s2, v_s3;
	logic signed [qte_pkg::QW-1:0] x_s1, y_s1, z_s1, w_s1;
	logic signed [qte_pkg::PW-1:0] wx_s2, yz_s2, wy_s2, zx_s2, wz_s2, xy_s2;
	logic signed [qte_pkg::PW-1:0] xx_s2, yy_s2, zz_s2;
	qte_pkg::terms_t t_s3;

	assign en = !v_s3 || q_ready;
	assign s_tready = en;
	assign q_valid = v_s3;
	assign q_data = t_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= s_tdata[15:0];
			y_s1 <= s_tdata[31:16];
			z_s1 <= s_tdata[47:32];
			w_s1 <= s_tdata[63:48];
			wx_s2 <= w_s1 * x_s1;
			yz_s2 <= y_s1 * z_s1;
			wy_s2 <= w_s1 * y_s1;
			zx_s2 <= z_s1 * x_s1;
			wz_s2 <= w_s1 * z_s1;
			xy_s2 <= x_s1 * y_s1;
			xx_s2 <= x_s1 * x_s1;
			yy_s2 <= y_s1 * y_s1;
			zz_s2 <= z_s1 * z_s1;
			t_s3.sinr <= (qte_pkg::TW'(wx_s2) + qte_pkg::TW'(yz_s2)) <<< 1;
			t_s3.cosr <= qte_pkg::ONE_Q28 -
				((qte_pkg::TW'(xx_s2) + qte_pkg::TW'(yy_s2)) <<< 1);
			t_s3.sinp <= (qte_pkg::TW'(wy_s2) - qte_pkg::TW'(zx_s2)) <<< 1;
			t_s3.siny <= (qte_pkg::TW'(wz_s2) + qte_pkg::TW'(xy_s2)) <<< 1;
			t_s3.cosy <= qte_pkg::ONE_Q28 -
				((qte_pkg::TW'(yy_s2) + qte_pkg::TW'(zz_s2)) <<< 1);
		end
	end

endmodule

// ===== design/qte_fifo.sv =====
// Short queue of term records between the front end and the back end.
// Depends on qte_pkg.
`timescale 1ns / 1ps
module qte_fifo #(
	parameter int DEPTH = qte_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  qte_pkg::terms_t in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output qte_pkg::terms_t out_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	qte_pkg::terms_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [NW-1:0] count_q;
	logic push, pop;

	assign in_ready = (count_q != NW'(DEPTH));
	assign out_valid = (count_q != '0);
	assign out_data = mem_q[rd_ptr_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

endmodule

// ===== design/qte_cordic.sv =====
// Pipelined two-argument arctangent by vectoring rotations, 25 stages,
// result in 1/128 degree before saturation. Depends on qte_pkg.
`timescale 1ns / 1ps
module qte_cordic (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [qte_pkg::TW-1:0] a_in,
	input  logic signed [qte_pkg::TW-1:0] b_in,
	output logic signed [qte_pkg::RW-1:0] r_out
);

	localparam int N = qte_pkg::STEPS;

	logic signed [qte_pkg::TW-1:0] a_c0, b_c0;
	logic signed [qte_pkg::ZW-1:0] z_c0;
	logic [5:0] sh_c0;
	logic zero_c0;

	logic signed [qte_pkg::CW-1:0] a_q [N+1];
	logic signed [qte_pkg::CW-1:0] b_q [N+1];
	logic signed [qte_pkg::ZW-1:0] z_q [N+1];
	logic zero_q [N+1];

	logic signed [qte_pkg::TW-1:0] a_neg, b_neg;
	logic signed [qte_pkg::ZW-1:0] z_init;
	logic [qte_pkg::TW-1:0] mag;
	logic [5:0] msb;
	logic signed [qte_pkg::ZW-1:0] z_rnd;

	// A vector in the left half plane is turned by a half turn first.
	always_comb begin
		if (b_in < 0) begin
			a_neg = -a_in;
			b_neg = -b_in;
			z_init = (a_in >= 0) ? qte_pkg::HALF_TURN : -qte_pkg::HALF_TURN;
		end else begin
			a_neg = a_in;
			b_neg = b_in;
			z_init = '0;
		end
		mag = ((a_neg < 0) ? -a_neg : a_neg) | b_neg;
		msb = '0;
		for (int i = 0; i < qte_pkg::TW; i++) begin
			if (mag[i]) begin
				msb = 6'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_c0 <= a_neg;
			b_c0 <= b_neg;
			z_c0 <= z_init;
			zero_c0 <= (a_in == 0) && (b_in == 0);
			sh_c0 <= 6'(qte_pkg::NORM_MSB) - msb;
			a_q[0] <= qte_pkg::CW'(a_c0) <<< sh_c0;
			b_q[0] <= qte_pkg::CW'(b_c0) <<< sh_c0;
			z_q[0] <= z_c0;
			zero_q[0] <= zero_c0;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		logic signed [qte_pkg::CW-1:0] da, db;
		assign da = b_q[i] >>> i;
		assign db = a_q[i] >>> i;
		always_ff @(posedge clk) begin
			if (en) begin
				zero_q[i+1] <= zero_q[i];
				if (a_q[i] > 0) begin
					b_q[i+1] <= b_q[i] + db;
					a_q[i+1] <= a_q[i] - da;
					z_q[i+1] <= z_q[i] + qte_pkg::ZW'(qte_pkg::ATAN_TAB[i]);
				end else begin
					b_q[i+1] <= b_q[i] - db;
					a_q[i+1] <= a_q[i] + da;
					z_q[i+1] <= z_q[i] - qte_pkg::ZW'(qte_pkg::ATAN_TAB[i]);
				end
			end
		end
	end

	assign z_rnd = (z_q[N] + qte_pkg::ZW'(256)) >>> 9;

	always_ff @(posedge clk) begin
		if (en) begin
			r_out <= zero_q[N] ? '0 : z_rnd[qte_pkg::RW-1:0];
		end
	end

endmodule

// ===== design/qte_back.sv =====
// Back end: clamps the pitch sine, takes the cosine by a pipelined square
// root, runs three arctangent pipelines and saturates into the output
// register. Depends on qte_pkg and qte_cordic.
`timescale 1ns / 1ps
module qte_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	output logic            q_ready,
	input  qte_pkg::terms_t q_data,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [47:0]     m_tdata   // roll_angle, pitch_angle, yaw_angle
);

	localparam int SQ = qte_pkg::SQ_STEPS;
	localparam int DLY = SQ + 1;
	localparam int PIPE = 1 + DLY + 25;

	logic en;
	logic [PIPE-1:0] v_q;
	logic m_valid_q;

	logic signed [qte_pkg::TW-1:0] sinr_s1, cosr_s1, siny_s1, cosy_s1, sinp_s1;
	logic signed [qte_pkg::TW-1:0] sinp_clamp;
	logic signed [2*SQ+1:0] sq;
	logic [qte_pkg::RADW-1:0] rad_s2;
	logic signed [qte_pkg::TW-1:0] sinp_s2;

	logic [qte_pkg::REMW-1:0] rem_q [SQ+1];
	logic [SQ-1:0] root_q [SQ+1];
	logic [qte_pkg::RADW-1:0] rad_q [SQ+1];
	logic signed [qte_pkg::TW-1:0] sinp_q [SQ+1];

	logic signed [qte_pkg::RW-1:0] roll_r, pitch_r, yaw_r;
	logic signed [qte_pkg::RW-1:0] roll_d [DLY];
	logic signed [qte_pkg::RW-1:0] yaw_d [DLY];
	logic signed [qte_pkg::TW-1:0] cosp;

	logic signed [qte_pkg::ROLLW-1:0] roll_q, yaw_q;
	logic signed [qte_pkg::PITCHW-1:0] pitch_q;

	function automatic logic signed [qte_pkg::RW-1:0] sat(
		input logic signed [qte_pkg::RW-1:0] r,
		input logic signed [qte_pkg::RW-1:0] lim
	);
		logic signed [qte_pkg::RW-1:0] o;
		if (r > lim) begin
			o = lim;
		end else if (r < -lim) begin
			o = -lim;
		end else begin
			o = r;
		end
		return o;
	endfunction

	assign en = !m_valid_q || m_tready;
	assign q_ready = en;
	assign m_tvalid = m_valid_q;
	assign m_tdata = {1'b0, yaw_q, pitch_q, roll_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
			m_valid_q <= 1'b0;
		end else if (en) begin
			v_q <= {v_q[PIPE-2:0], q_valid};
			m_valid_q <= v_q[PIPE-1];
		end
	end

	always_comb begin
		if (q_data.sinp > qte_pkg::ONE_Q28) begin
			sinp_clamp = qte_pkg::ONE_Q28;
		end else if (q_data.sinp < -qte_pkg::ONE_Q28) begin
			sinp_clamp = -qte_pkg::ONE_Q28;
		end else begin
			sinp_clamp = q_data.sinp;
		end
	end

	// The clamped sine fits in the low bits, which are squared as a signed value.
	assign sq = $signed(sinp_s1[SQ:0]) * $signed(sinp_s1[SQ:0]);

	always_ff @(posedge clk) begin
		if (en) begin
			sinr_s1 <= q_data.sinr;
			cosr_s1 <= q_data.cosr;
			siny_s1 <= q_data.siny;
			cosy_s1 <= q_data.cosy;
			sinp_s1 <= sinp_clamp;
			rad_s2 <= (qte_pkg::RADW'(1) << 56) - qte_pkg::RADW'(sq);
			sinp_s2 <= sinp_s1;
		end
	end

	assign rem_q[0] = '0;
	assign root_q[0] = '0;
	assign rad_q[0] = rad_s2;
	assign sinp_q[0] = sinp_s2;

	// One root bit per stage, restoring method on bit pairs.
	for (genvar k = 0; k < SQ; k++) begin : g_sqrt
		logic [qte_pkg::REMW-1:0] r2, t;
		assign r2 = {rem_q[k][qte_pkg::REMW-3:0], rad_q[k][qte_pkg::RADW-1 -: 2]};
		assign t = qte_pkg::REMW'({root_q[k], 2'b01});
		always_ff @(posedge clk) begin
			if (en) begin
				rad_q[k+1] <= rad_q[k] << 2;
				sinp_q[k+1] <= sinp_q[k];
				if (r2 >= t) begin
					rem_q[k+1] <= r2 - t;
					root_q[k+1] <= {root_q[k][SQ-2:0], 1'b1};
				end else begin
					rem_q[k+1] <= r2;
					root_q[k+1] <= {root_q[k][SQ-2:0], 1'b0};
				end
			end
		end
	end

	assign cosp = qte_pkg::TW'({1'b0, root_q[SQ]});

	qte_cordic u_roll (.clk(clk), .en(en), .a_in(sinr_s1), .b_in(cosr_s1), .r_out(roll_r));
	qte_cordic u_yaw (.clk(clk), .en(en), .a_in(siny_s1), .b_in(cosy_s1), .r_out(yaw_r));
	qte_cordic u_pitch (.clk(clk), .en(en), .a_in(sinp_q[SQ]), .b_in(cosp), .r_out(pitch_r));

	// Roll and yaw wait for the square root of the pitch path.
	always_ff @(posedge clk) begin
		if (en) begin
			roll_d[0] <= roll_r;
			yaw_d[0] <= yaw_r;
			for (int i = 1; i < DLY; i++) begin
				roll_d[i] <= roll_d[i-1];
				yaw_d[i] <= yaw_d[i-1];
			end
			roll_q <= qte_pkg::ROLLW'(sat(roll_d[DLY-1], qte_pkg::LIM_HALF));
			yaw_q <= qte_pkg::ROLLW'(sat(yaw_d[DLY-1], qte_pkg::LIM_HALF));
			pitch_q <= qte_pkg::PITCHW'(sat(pitch_r, qte_pkg::LIM_QUARTER));
		end
	end

endmodule

// ===== design/quaternion_to_euler_angles_unit.sv =====
// Quaternion to roll, pitch and yaw converter, one transaction per cycle
// unless the output stalls on m_tready. The path holds 3 front stages, the queue
// write, 56 back stages (29 of them the pitch square root, 25 the
// arctangent pipelines) and the output register.
// Reset clears only valid bits, queue pointers and the queue count; data registers are not reset.
`timescale 1ns / 1ps
module quaternion_to_euler_angles_unit #(
	parameter int QUEUE_DEPTH = qte_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // quat_x, quat_y, quat_z, quat_w
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // roll_angle, pitch_angle, yaw_angle
);

	logic f_valid, f_ready, b_valid, b_ready;
	qte_pkg::terms_t f_data, b_data;

	qte_front u_front (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.q_valid(f_valid), .q_ready(f_ready), .q_data(f_data)
	);

	qte_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
		.out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
	);

	qte_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(b_valid), .q_ready(b_ready), .q_data(b_data),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench of the quaternion to Euler angle converter.
// Holds its own fixed-point predictor and needs only the design files.
`timescale 1ns / 1ps
module tb_top;

	typedef struct {
		logic signed [15:0] roll;
		logic signed [14:0] pitch;
		logic signed [15:0] yaw;
	} angles_t;

	localparam longint UNIT_Q28 = 64'sd1 << 28;
	localparam longint NORM_BOUND = 64'sd1 << 40;
	localparam longint HALF_TURN_FINE = 64'sd180 * 65536;
	localparam int ANGLE_STEPS = 22;
	localparam int DRAIN_CYCLES = 100;
	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 1600;

	localparam longint ATAN_FINE [ANGLE_STEPS] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58670, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2
	};

	function automatic longint atan2_angle(longint a, longint b, longint lim);
		longint z;
		longint da, db, r;
		z = 0;
		if (a == 0 && b == 0)
			return 0;
		if (b < 0) begin
			z = (a >= 0) ? HALF_TURN_FINE : -HALF_TURN_FINE;
			a = -a;
			b = -b;
		end
		while ((a < 0 ? -a : a) < NORM_BOUND && (b < 0 ? -b : b) < NORM_BOUND) begin
			a = a * 2;
			b = b * 2;
		end
		for (int i = 0; i < ANGLE_STEPS; i++) begin
			da = b >>> i;
			db = a >>> i;
			if (a > 0) begin
				b = b + db;
				a = a - da;
				z = z + ATAN_FINE[i];
			end else begin
				b = b - db;
				a = a + da;
				z = z - ATAN_FINE[i];
			end
		end
		r = (z + 256) >>> 9;
		if (r > lim)
			r = lim;
		if (r < -lim)
			r = -lim;
		return r;
	endfunction

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned res, bit_pos;
		res = 0;
		bit_pos = 64'd1 << 62;
		while (bit_pos > v)
			bit_pos = bit_pos >> 2;
		while (bit_pos != 0) begin
			if (v >= res + bit_pos) begin
				v = v - (res + bit_pos);
				res = (res >> 1) + bit_pos;
			end else begin
				res = res >> 1;
			end
			bit_pos = bit_pos >> 2;
		end
		return res;
	endfunction

	function automatic angles_t euler_from_quat(logic [63:0] q);
		longint x, y, z, w;
		longint sinr, cosr, sinp, siny, cosy, cosp;
		angles_t res;
		x = longint'($signed(q[15:0]));
		y = longint'($signed(q[31:16]));
		z = longint'($signed(q[47:32]));
		w = longint'($signed(q[63:48]));
		sinr = 2 * (w * x + y * z);
		cosr = UNIT_Q28 - 2 * (x * x + y * y);
		sinp = 2 * (w * y - z * x);
		siny = 2 * (w * z + x * y);
		cosy = UNIT_Q28 - 2 * (y * y + z * z);
		if (sinp > UNIT_Q28)
			sinp = UNIT_Q28;
		if (sinp < -UNIT_Q28)
			sinp = -UNIT_Q28;
		cosp = longint'(root_floor(longint'(UNIT_Q28 * UNIT_Q28) - sinp * sinp));
		res.roll = 16'(atan2_angle(sinr, cosr, 23040));
		res.pitch = 15'(atan2_angle(sinp, cosp, 11520));
		res.yaw = 16'(atan2_angle(siny, cosy, 23040));
		return res;
	endfunction

	class angle_scoreboard;
		angles_t pending[$];
		int errors;
		int received;

		function new();
			errors = 0;
			received = 0;
		endfunction

		task report(string what, int got, int want);
			$display("mismatch at result %0d: %s got %0d expected %0d",
				received, what, got, want);
			errors++;
		endtask

		task note_input(logic [63:0] q);
			pending.push_back(euler_from_quat(q));
		endtask

		task check_result(logic [47:0] d);
			angles_t want;
			received++;
			if (pending.size() == 0) begin
				$display("unexpected result %0d: %h", received, d);
				errors++;
				return;
			end
			want = pending.pop_front();
			if ($signed(d[15:0]) !== want.roll)
				report("roll", $signed(d[15:0]), want.roll);
			if ($signed(d[30:16]) !== want.pitch)
				report("pitch", $signed(d[30:16]), want.pitch);
			if ($signed(d[46:31]) !== want.yaw)
				report("yaw", $signed(d[46:31]), want.yaw);
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [63:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [47:0] m_tdata;

	angle_scoreboard board;
	logic [63:0] quat_list[$];
	bit sending_done = 0;
	int idle_cycles = 0;

	quaternion_to_euler_angles_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #4 clk = ~clk;

	function automatic logic [63:0] pack_quat(int x, int y, int z, int w);
		return {16'(w), 16'(z), 16'(y), 16'(x)};
	endfunction

	function automatic int draw_component(int mode);
		case (mode)
			0: return int'($urandom_range(65535)) - 32768;
			1: return int'($urandom_range(8)) - 4;
			default: return int'($urandom_range(32768)) - 16384;
		endcase
	endfunction

	task send_quats();
		int gap;
		foreach (quat_list[i]) begin
			gap = $urandom_range(5);
			if ($urandom_range(3) == 0)
				gap = 0;
			if (gap > 0) begin
				s_tvalid <= 0;
				repeat (gap) @(posedge clk);
			end
			s_tvalid <= 1;
			s_tdata <= quat_list[i];
			do @(posedge clk); while (!s_tready);
			board.note_input(quat_list[i]);
		end
		s_tvalid <= 0;
		sending_done = 1;
	endtask

	task collect_angles();
		int gap;
		bit stalled;
		stalled = 0;
		forever begin
			gap = $urandom_range(5);
			if ($urandom_range(3) == 0)
				gap = 0;
			// One long hold-off so the queue fills and the input stalls.
			if (!stalled && board.received == 200) begin
				stalled = 1;
				gap = 300;
			end
			if (gap > 0) begin
				m_tready <= 0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1;
			do @(posedge clk); while (!m_tvalid);
			board.check_result(m_tdata);
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL quaternion_to_euler_angles_unit");
			$finish;
		end
	end

	initial begin
		int mode;
		board = new();
		// Directed cases: zero, identity, negative x axis, clamped pitch, extremes.
		quat_list.push_back(pack_quat(0, 0, 0, 0));
		quat_list.push_back(pack_quat(0, 0, 0, 16384));
		quat_list.push_back(pack_quat(16384, 0, 0, 0));
		quat_list.push_back(pack_quat(0, 0, 16384, 0));
		quat_list.push_back(pack_quat(0, 16384, 0, 0));
		quat_list.push_back(pack_quat(0, 11585, 0, 11585));
		quat_list.push_back(pack_quat(0, -11585, 0, 11585));
		quat_list.push_back(pack_quat(0, 32767, 0, 32767));
		quat_list.push_back(pack_quat(0, 32767, 0, -32768));
		quat_list.push_back(pack_quat(8192, 8192, 8192, 8192));
		quat_list.push_back(pack_quat(-32768, -32768, -32768, -32768));
		quat_list.push_back(pack_quat(32767, 32767, 32767, 32767));
		quat_list.push_back(pack_quat(-32768, 32767, -32768, 32767));
		quat_list.push_back(pack_quat(32767, -32768, 32767, -32768));
		quat_list.push_back(pack_quat(1, 0, 0, 0));
		quat_list.push_back(pack_quat(-1, 0, 0, 0));
		quat_list.push_back(pack_quat(0, 0, 0, -1));
		quat_list.push_back(pack_quat(0, 0, -1, 0));
		quat_list.push_back(pack_quat(11585, 0, 0, 11585));
		quat_list.push_back(pack_quat(0, 0, 11585, -11585));
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			mode = $urandom_range(5);
			if (mode > 2)
				mode = 0;
			quat_list.push_back(pack_quat(draw_component(mode), draw_component(mode),
				draw_component(mode), draw_component(mode)));
		end

		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		fork
			send_quats();
			collect_angles();
		join_none
		while (!(sending_done && board.pending.size() == 0))
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("PASS quaternion_to_euler_angles_unit");
		else
			$display("FAIL quaternion_to_euler_angles_unit");
		$finish;
	end

endmodule
